// ===== rtl/mis_pkg.sv =====
// ----------------------------------------------------------------------------
// mis_pkg: shared definitions of the merge insertion sorter
// Data width, default capacity and the control bundle that the top level
// broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package mis_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // Control broadcast to all cells in the same cycle.
  typedef struct packed {
    logic              insert;  // place ins_value into the sorted row
    logic              shift;   // move every entry one cell toward the head
    logic [DATA_W-1:0] ins_value;
  } cell_ctrl_t;

endpackage

// ===== rtl/mis_cell.sv =====
// ----------------------------------------------------------------------------
// mis_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps, takes the new value, or takes its
// lower neighbor's entry; on shift it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module mis_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  mis_pkg::cell_ctrl_t           ctrl,
  input  logic                          prev_gt,
  input  logic                          prev_valid,
  input  logic [mis_pkg::DATA_W-1:0]    prev_value,
  input  logic                          next_valid,
  input  logic [mis_pkg::DATA_W-1:0]    next_value,
  output logic                          gt,
  output logic                          valid,
  output logic [mis_pkg::DATA_W-1:0]    value
);
  import mis_pkg::*;

  // An empty slot counts as larger than any value.
  assign gt = !valid || (value > ctrl.ins_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && gt) begin
      valid <= valid | (prev_gt ? prev_valid : 1'b1);
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      value <= prev_gt ? prev_value : ctrl.ins_value;
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

endmodule

// ===== rtl/merge_insertion_sorter_top.sv =====
// ----------------------------------------------------------------------------
// merge_insertion_sorter_top: streaming insertion sorter on a row of cells
// The first result is offered in the cycle after the final request.
// Throughput: one input request per cycle while collecting; one result per
// cycle while draining unless out_stall holds it, and input is stalled for the whole drain.
// Reset: synchronous, active high; empties every cell and clears the flags.
// ----------------------------------------------------------------------------
module merge_insertion_sorter_top #(
  parameter int MAX_ITEMS = mis_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mis_pkg::DATA_W-1:0]    value,
  input  logic                          final_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mis_pkg::DATA_W-1:0]    sorted_value,
  output logic                          last,
  output logic                          dropped
);
  import mis_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // The row of cells is always kept sorted, smallest entry in cell 0. Each
  // incoming request is compared against every cell at once: cells whose
  // entry is larger than the new value move up by one, and the first of
  // them takes the new value. Equal entries stay ahead of the new one.
  // After the final request the row drains through cell 0, moving down by
  // one cell for every result taken.

  logic             draining;
  logic             overflow_seen;
  logic [CNT_W-1:0] item_count;

  logic             in_acc;
  logic             out_acc;
  logic             full;
  cell_ctrl_t       ctrl;

  logic [MAX_ITEMS-1:0] cell_gt;
  logic [MAX_ITEMS-1:0] cell_valid;
  logic [DATA_W-1:0]    cell_value [MAX_ITEMS];

  assign in_stall = draining;
  assign in_acc   = in_valid && !draining;
  assign out_acc  = out_valid && !out_stall;
  assign full     = (item_count == CNT_W'(MAX_ITEMS));

  assign ctrl.insert    = in_acc && !full;
  assign ctrl.shift     = out_acc;
  assign ctrl.ins_value = value;

  // Results come straight from cell 0, which changes only when a result is
  // taken, so a stalled result holds.
  assign out_valid    = draining;
  assign sorted_value = cell_value[0];
  assign last         = (item_count == CNT_W'(1));
  assign dropped      = overflow_seen;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic              p_gt;
    logic              p_valid;
    logic [DATA_W-1:0] p_value;
    logic              n_valid;
    logic [DATA_W-1:0] n_value;

    if (i == 0) begin : g_head
      assign p_gt    = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = '0;
    end else begin : g_body
      assign p_gt    = cell_gt[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_value = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_mid
      assign n_valid = cell_valid[i+1];
      assign n_value = cell_value[i+1];
    end

    mis_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_gt    (p_gt),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .gt         (cell_gt[i]),
      .valid      (cell_valid[i]),
      .value      (cell_value[i])
    );
  end

  // Collect and drain control. A request that meets a full row is
  // discarded and sets the sticky overflow flag; the final request always
  // starts a drain, since the row then holds at least one entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining      <= 1'b0;
      overflow_seen <= 1'b0;
      item_count    <= '0;
    end else if (draining) begin
      if (out_acc) begin
        if (last) begin
          draining      <= 1'b0;
          overflow_seen <= 1'b0;
          item_count    <= '0;
        end else begin
          item_count <= item_count - CNT_W'(1);
        end
      end
    end else if (in_acc) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        item_count <= item_count + CNT_W'(1);
      end
      if (final_item) begin
        draining <= 1'b1;
      end
    end
  end

  // A result on offer always comes from an occupied head cell.
  a_head_valid : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_valid[0])
    else $error("result offered from an empty head cell");

  // The entry count never passes the row length.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS))
    else $error("entry count beyond capacity");

  // Taking the last result ends the drain and leaves the row empty.
  a_drain_end : assert property (@(posedge clk) disable iff (rst)
    (out_acc && last) |=> (!out_valid && !cell_valid[0] && item_count == '0))
    else $error("drain did not end after the last result");

  // The final request starts a drain in the next cycle.
  a_drain_start : assert property (@(posedge clk) disable iff (rst)
    (in_acc && final_item) |=> out_valid)
    else $error("no drain after the final request");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the merge insertion sorter
// Lists of 32-bit values are pushed in with random gaps, and the sorted runs
// are taken out under random stall. Every run is checked value by value,
// including the last and dropped flags, against a sorted store in the bench.
// ----------------------------------------------------------------------------

// One expected result of a sorted run.
typedef struct packed {
  logic [mis_pkg::DATA_W-1:0] sorted_value;
  logic                       last;
  logic                       dropped;
} sorted_result_t;

// Keeps the list that is being collected in ascending order and queues the
// results that each final request releases.
class sort_board;
  logic [mis_pkg::DATA_W-1:0] held_values [mis_pkg::MAX_ITEMS_DEF];
  int unsigned                held_count;
  bit                         overflow_seen;
  sorted_result_t             awaited [$];
  int unsigned                failures;

  function new();
    held_count    = 0;
    overflow_seen = 1'b0;
    failures      = 0;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  function void note_request(logic [mis_pkg::DATA_W-1:0] v, logic fin);
    int unsigned    pos;
    sorted_result_t r;
    if (held_count >= mis_pkg::MAX_ITEMS_DEF) begin
      overflow_seen = 1'b1;
    end else begin
      // Equal values stay ahead of the newcomer.
      pos = held_count;
      while (pos > 0 && held_values[pos-1] > v) begin
        held_values[pos] = held_values[pos-1];
        pos--;
      end
      held_values[pos] = v;
      held_count++;
    end
    if (fin) begin
      for (int unsigned k = 0; k < held_count; k++) begin
        r.sorted_value = held_values[k];
        r.last         = (k + 1 == held_count);
        r.dropped      = overflow_seen;
        awaited.insert(awaited.size(), r);
      end
      held_count    = 0;
      overflow_seen = 1'b0;
    end
  endfunction

  function void check_result(logic [mis_pkg::DATA_W-1:0] sv, logic lst, logic drp);
    sorted_result_t e;
    if (awaited.size() == 0) begin
      $display("%0t: result with nothing expected: value %h last %b dropped %b",
               $time, sv, lst, drp);
      failures++;
      return;
    end
    e = awaited.pop_front();
    if (sv !== e.sorted_value) begin
      $display("%0t: sorted_value expected %h actual %h", $time, e.sorted_value, sv);
      failures++;
    end
    if (lst !== e.last) begin
      $display("%0t: last expected %b actual %b", $time, e.last, lst);
      failures++;
    end
    if (drp !== e.dropped) begin
      $display("%0t: dropped expected %b actual %b", $time, e.dropped, drp);
      failures++;
    end
  endfunction
endclass

module tb_top;

  localparam int SORT_DEPTH  = mis_pkg::MAX_ITEMS_DEF;
  // The stimulus stops once this many requests have gone in.
  localparam int TOTAL_ITEMS = 470;
  // Past this count neither side idles any more.
  localparam int CALM_AFTER  = 400;
  // Cycles without any accepted request or result before the run is abandoned.
  // The longest legal stretch is the reset plus the final settle, so this
  // leaves a wide margin.
  localparam int IDLE_LIMIT  = 1000;
  // Cycles of settle after the last expected result, to catch stray results.
  localparam int SETTLE      = 20;

  logic                       clk;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [mis_pkg::DATA_W-1:0] value        = '0;
  logic                       final_item   = 1'b0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [mis_pkg::DATA_W-1:0] sorted_value;
  logic                       last;
  logic                       dropped;

  // Set near the end of the run so that the last requests and results flow
  // back to back.
  logic                       no_idle      = 1'b0;

  sort_board  board;
  int         items_sent;
  int         stall_burst  = 0;
  int         quiet_cycles = 0;

  merge_insertion_sorter_top #(
    .MAX_ITEMS(SORT_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .final_item   (final_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last         (last),
    .dropped      (dropped)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Values are mostly uniform over the full range, so every bit toggles.
  // A share come from a tiny range to force duplicates, and a share are the
  // edges of the range.
  function automatic logic [mis_pkg::DATA_W-1:0] draw_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      return $urandom();
    end else if (pick < 8) begin
      return $urandom_range(0, 7);
    end
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Presents one request and returns at the edge where it is taken. Before
  // the request the sender may idle for a short burst.
  task automatic send_request(input logic [mis_pkg::DATA_W-1:0] v, input logic fin);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    final_item <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sends a list of random values; only its last request carries the flag.
  task automatic send_list(input int len);
    for (int k = 0; k < len; k++) begin
      send_request(draw_value(), k == len - 1);
    end
  endtask

  // Holds the sender off until every expected result has been taken. The
  // first edge gives the monitor time to note the request just accepted.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Every accepted request goes into the sorted store of the bench. Signals
  // are read at the edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      board.note_request(value, final_item);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(sorted_value, last, dropped);
    end
  end

  // The receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall   <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      stall_burst <= $urandom_range(0, 2);
      out_stall   <= 1'b1;
    end else begin
      out_stall   <= 1'b0;
    end
  end

  // A run that stops moving is a failure.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int len;
    int list_no;
    board        = new();
    items_sent   = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lists. A lone final request gives a run of one, at both ends
    // of the range.
    send_request(32'h0000_0000, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b1);
    // The edges of the range out of order.
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'h0000_0001, 1'b1);
    // Duplicates must all come out, next to each other.
    send_request(32'd5, 1'b0);
    send_request(32'd5, 1'b0);
    send_request(32'd3, 1'b0);
    send_request(32'd5, 1'b0);
    send_request(32'd3, 1'b1);
    // The same value throughout, at the top of the range.
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);
    // Already ascending, then strictly descending.
    send_request(32'd1, 1'b0);
    send_request(32'd2, 1'b0);
    send_request(32'd3, 1'b0);
    send_request(32'd4, 1'b1);
    send_request(32'd9, 1'b0);
    send_request(32'd8, 1'b0);
    send_request(32'd7, 1'b0);
    send_request(32'd6, 1'b1);
    wait_for_drain();

    // Random lists. Most are short; a few fill the store exactly, let the
    // final request meet a full store, or overflow well past capacity.
    list_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (list_no)
        2:       len = SORT_DEPTH;
        5:       len = SORT_DEPTH + 1;
        9:       len = SORT_DEPTH + 6;
        default: begin
          case ($urandom_range(0, 19))
            0:       len = $urandom_range(SORT_DEPTH - 4, SORT_DEPTH + 8);
            1, 2, 3: len = $urandom_range(11, 40);
            default: len = $urandom_range(1, 10);
          endcase
        end
      endcase
      // The last list is cut short so that the total lands on the target.
      if (len > TOTAL_ITEMS - items_sent) begin
        len = TOTAL_ITEMS - items_sent;
      end
      if (items_sent >= CALM_AFTER) begin
        no_idle <= 1'b1;
      end
      send_list(len);
      // Now and then the sender waits for the whole run to come out.
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        wait_for_drain();
      end
      list_no++;
    end

    // All requests are in; wait for the last run, then a little longer.
    wait_for_drain();
    repeat (SETTLE) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
